>>> rtl/hscf_pkg.sv
package hscf_pkg;

    // set geometry (both must be powers of two, pool a multiple of 32, buckets >= pool rows)
    localparam int BUCKETS    = 1024;
    localparam int POOL_NODES = 1024;

    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 3;
    localparam int NODE_W  = $clog2(POOL_NODES) + 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int COL_W   = 5;
    localparam int ROW_BITS = 1 << COL_W;
    localparam int ROWS    = POOL_NODES / ROW_BITS;
    localparam int ROW_W   = $clog2(ROWS);

    localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL_NODES);

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_HEADW,
        S_CHK,
        S_NODEW,
        S_UNLINK,
        S_URD,
        S_UWR,
        S_SRD,
        S_SCHK,
        S_INS,
        S_LINK,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    clear_step;
        logic    load;
        logic    hash_step;
        logic    cur_from_head;
        logic    walk_adv;
        logic    walk_hit;
        logic    row_zero;
        logic    row_inc;
        logic    used_set;
        logic    used_clr;
        logic    unlink;
        logic    ins_write;
        logic    link_write;
        logic    count_inc;
        logic    count_dec;
        logic    out_load;
        status_t status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic    clear_done;
        logic    hash_last;
        logic    cur_nil;
        logic    key_match;
        logic    pool_full;
        logic    row_has_free;
        logic    out_busy;
        opcode_t opcode;
    } stat_t;

endpackage

>>> rtl/hscf_ram.sv
module hscf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/hscf_ctrl.sv
module hscf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  hscf_pkg::stat_t stat,
    output hscf_pkg::cmd_t  cmd
);
    import hscf_pkg::*;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            st_reg    <= ST_ABSENT;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.status = st_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last) begin
                    if (stat.opcode == OP_NONE) begin
                        st_next    = ST_ABSENT;
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: state_next = S_HEADW;
            S_HEADW: begin
                cmd.cur_from_head = 1'b1;
                state_next        = S_CHK;
            end
            S_CHK: begin
                if (!stat.cur_nil) begin
                    state_next = S_NODEW;
                end else if (stat.opcode != OP_INSERT) begin
                    st_next    = ST_ABSENT;
                    state_next = S_RESULT;
                end else if (stat.pool_full) begin
                    st_next    = ST_FULL;
                    state_next = S_RESULT;
                end else begin
                    cmd.row_zero = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_NODEW: begin
                if (stat.key_match) begin
                    cmd.walk_hit = 1'b1;
                    case (stat.opcode)
                        OP_INSERT: begin
                            st_next    = ST_DUPLICATE;
                            state_next = S_RESULT;
                        end
                        OP_FIND: begin
                            st_next    = ST_FOUND;
                            state_next = S_RESULT;
                        end
                        default: state_next = S_UNLINK;
                    endcase
                end else begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_CHK;
                end
            end
            S_UNLINK: begin
                cmd.unlink = 1'b1;
                state_next = S_URD;
            end
            S_URD: state_next = S_UWR;
            S_UWR: begin
                cmd.used_clr  = 1'b1;
                cmd.count_dec = 1'b1;
                st_next       = ST_REMOVED;
                state_next    = S_RESULT;
            end
            S_SRD: state_next = S_SCHK;
            S_SCHK: begin
                if (stat.row_has_free) begin
                    cmd.used_set = 1'b1;
                    state_next   = S_INS;
                end else begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_INS: begin
                cmd.ins_write = 1'b1;
                state_next    = S_LINK;
            end
            S_LINK: begin
                cmd.link_write = 1'b1;
                cmd.count_inc  = 1'b1;
                st_next        = ST_INSERTED;
                state_next     = S_RESULT;
            end
            S_RESULT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/hscf_dp.sv
module hscf_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hscf_pkg::cmd_t                cmd,
    output hscf_pkg::stat_t               stat,
    input  logic [hscf_pkg::OP_W-1:0]     in_opcode,
    input  logic signed [hscf_pkg::KEY_W-1:0] in_key,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [hscf_pkg::ST_W-1:0]     m_status,
    output logic [hscf_pkg::NODE_W-1:0]   m_count
);
    import hscf_pkg::*;

    // request and walk registers
    opcode_t            op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [31:0]        hash_reg, hash_next;
    logic [1:0]         hcnt_reg;
    logic [NODE_W-1:0]  cur_reg, p_reg, nxt_reg, steps_reg;
    logic [NODE_W-2:0]  hit_reg, f_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [BKT_W-1:0]   clr_reg;
    logic [NODE_W-1:0]  count_reg;
    logic               m_valid_reg;
    logic [ST_W-1:0]    m_status_reg;
    logic [NODE_W-1:0]  m_count_reg;

    // memory ports
    logic               head_we;
    logic [BKT_W-1:0]   head_waddr;
    logic [NODE_W-1:0]  head_wdata, head_rdata;
    logic               nk_we;
    logic [KEY_W-1:0]   nk_rdata;
    logic               nn_we;
    logic [NODE_W-2:0]  nn_waddr;
    logic [NODE_W-1:0]  nn_wdata, nn_rdata;
    logic               used_we;
    logic [ROW_W-1:0]   used_waddr;
    logic [ROW_BITS-1:0] used_wdata, used_rdata;

    logic [BKT_W-1:0]   bucket;
    logic [COL_W-1:0]   free_col;
    logic               row_free;
    logic               p_nil;

    assign bucket = hash_reg[BKT_W-1:0];
    assign p_nil  = (p_reg >= NIL);
    assign hash_next = (hash_reg ^ {24'd0, key_reg[8*hcnt_reg +: 8]}) * FNV_PRIME;

    // lowest clear bit of the used row
    always_comb begin
        free_col = '0;
        row_free = 1'b0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!used_rdata[i]) begin
                free_col = COL_W'(i);
                row_free = 1'b1;
            end
        end
    end

    // memory write selection
    always_comb begin
        head_we    = 1'b0;
        head_waddr = bucket;
        head_wdata = NIL;
        nk_we      = 1'b0;
        nn_we      = 1'b0;
        nn_waddr   = p_reg[NODE_W-2:0];
        nn_wdata   = nxt_reg;
        used_we    = 1'b0;
        used_waddr = row_reg;
        used_wdata = used_rdata;
        if (cmd.clear_step) begin
            head_we    = 1'b1;
            head_waddr = clr_reg;
            used_we    = (32'(clr_reg) < ROWS);
            used_waddr = clr_reg[ROW_W-1:0];
            used_wdata = '0;
        end
        if (cmd.unlink) begin
            head_we    = p_nil;
            head_wdata = nxt_reg;
            nn_we      = !p_nil;
        end
        if (cmd.ins_write) begin
            head_we    = p_nil;
            head_wdata = {1'b0, f_reg};
            nk_we      = 1'b1;
            nn_we      = 1'b1;
            nn_waddr   = f_reg;
            nn_wdata   = NIL;
        end
        if (cmd.link_write) begin
            nn_we    = !p_nil;
            nn_wdata = {1'b0, f_reg};
        end
        if (cmd.used_set) begin
            used_we    = 1'b1;
            used_wdata = used_rdata | (ROW_BITS'(1) << free_col);
        end
        if (cmd.used_clr) begin
            used_we    = 1'b1;
            used_wdata = used_rdata & ~(ROW_BITS'(1) << hit_reg[COL_W-1:0]);
        end
    end

    hscf_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(bucket), .rdata(head_rdata)
    );

    hscf_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_nkey (
        .aclk(aclk), .we(nk_we), .waddr(f_reg), .wdata(key_reg),
        .raddr(cur_reg[NODE_W-2:0]), .rdata(nk_rdata)
    );

    hscf_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_nnext (
        .aclk(aclk), .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
        .raddr(cur_reg[NODE_W-2:0]), .rdata(nn_rdata)
    );

    hscf_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_used (
        .aclk(aclk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
        .raddr(row_reg), .rdata(used_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.count_dec && count_reg != '0) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= opcode_t'(in_opcode);
            key_reg  <= in_key;
            hash_reg <= FNV_BASIS;
            hcnt_reg <= '0;
        end
        if (cmd.hash_step) begin
            hash_reg <= hash_next;
            hcnt_reg <= hcnt_reg + 1'b1;
        end
        if (cmd.cur_from_head) begin
            cur_reg   <= head_rdata;
            p_reg     <= NIL;
            steps_reg <= '0;
        end
        if (cmd.walk_adv) begin
            p_reg     <= cur_reg;
            cur_reg   <= nn_rdata;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.walk_hit) begin
            hit_reg <= cur_reg[NODE_W-2:0];
            nxt_reg <= nn_rdata;
            row_reg <= cur_reg[COL_W +: ROW_W];
        end
        if (cmd.row_zero) begin
            row_reg <= '0;
        end
        if (cmd.row_inc) begin
            row_reg <= row_reg + 1'b1;
        end
        if (cmd.used_set) begin
            f_reg <= {row_reg, free_col};
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.status;
            m_count_reg  <= count_reg;
        end
    end

    assign stat.clear_done   = (clr_reg == BKT_W'(BUCKETS - 1));
    assign stat.hash_last    = (hcnt_reg == 2'd3);
    assign stat.cur_nil      = (cur_reg >= NIL) || (steps_reg == NIL);
    assign stat.key_match    = (nk_rdata == key_reg);
    assign stat.pool_full    = (count_reg == NIL);
    assign stat.row_has_free = row_free;
    assign stat.out_busy     = m_valid_reg && !m_tready;
    assign stat.opcode       = op_reg;

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

endmodule

>>> rtl/hash_set_chained_fnv_core.sv
// Hash set of 32-bit signed keys, chained buckets, FNV-1a hash.
// Input stream (s_): one request per transfer, opcode insert/find/remove (3: no-op, reports absent).
// Output stream (m_): one result per request, status code and the
// element count after the request.
// Sequence: hashing does one multiply per key byte, then the bucket head
// is read and the chain is walked one node at a time. Remove then unlinks
// the node and does a used-bitmap read-modify-write. A new insert scans the
// used bitmap 32 nodes per row, then writes the node and links it.
// One request is in flight at a time; the next is taken once the current
// result sits in the output register, which holds it while m_tready is
// low; a finished request waits in the result state until the output slot frees up.
// After reset the bucket heads and used bitmap are cleared, one bucket a
// cycle, with s_tready low.
module hash_set_chained_fnv_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] opcode, [33:2] key, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [13:3] element_count, rest zero
);
    import hscf_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [ST_W-1:0]    m_status;
    logic [NODE_W-1:0]  m_count;

    hscf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    hscf_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_opcode(s_tdata[OP_W-1:0]), .in_key(s_tdata[OP_W +: KEY_W]),
        .m_tready(m_tready), .m_tvalid(m_tvalid),
        .m_status(m_status), .m_count(m_count)
    );

    assign m_tdata = {(16 - ST_W - NODE_W)'(0), m_count, m_status};

    // no node write when the pool is exhausted
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_write |-> !stat.pool_full) else $error("insert into full pool");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid && !m_tready)) else $error("result overwritten");

    // reported count stays within the pool
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_count <= NIL)) else $error("count out of range");

    // reported status is a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_status <= ST_FULL)) else $error("bad status code");

endmodule
